// ===== rtl/sfd_pkg.sv =====
// Shared types and constants of the SBUS frame decoder.
`timescale 1ns / 1ps
package sfd_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h0F;
    localparam logic [7:0]  ZERO_BYTE   = 8'h00;
    localparam int          STORE_BYTES = 23;
    localparam int          CH_W        = 11;
    localparam int          N_ANALOG    = 16;
    localparam int          DATA_W      = N_ANALOG * CH_W;
    localparam int          SHIFT_W     = STORE_BYTES * 8;
    localparam logic [4:0]  FIRST_DATA  = 5'd1;
    localparam logic [4:0]  FLAG_BYTE   = 5'd23;
    localparam logic [4:0]  END_BYTE    = 5'd24;
    localparam logic [4:0]  LAST_CH     = 5'd17;
    localparam logic [10:0] DIGITAL_ON  = 11'h7FF;
    localparam logic [10:0] DIGITAL_OFF = 11'h000;

    typedef enum logic [1:0] {
        PH_EXPECT = 2'd0,
        PH_HUNT   = 2'd1,
        PH_FRAME  = 2'd2
    } t_phase;

    // One completed frame as handed from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        dig;
        logic              failsafe;
    } t_frame;

endpackage

// ===== rtl/sfd_byte_if.sv =====
// Byte input channel: valid, ready and one received byte.
`timescale 1ns / 1ps
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sfd_chan_if.sv =====
// Channel result channel: valid, ready and one decoded channel.
`timescale 1ns / 1ps
interface sfd_chan_if;
    logic        valid;
    logic        ready;
    logic [4:0]  channel_index;
    logic [10:0] channel_value;
    logic        failsafe;
    logic        last;

    modport source (output valid, output channel_index, output channel_value,
                    output failsafe, output last, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input failsafe, input last, output ready);
endinterface

// ===== rtl/sfd_front.sv =====
// Front end: frame sync, byte capture and hand-off of completed frames.
`timescale 1ns / 1ps
module sfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sfd_byte_if.sink       i_rx,
    input  logic           i_q_full,
    output logic           o_push,
    output sfd_pkg::t_frame o_frame
);

    sfd_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_count, n_count;
    logic        r_prev_zero, n_prev_zero;
    logic [sfd_pkg::SHIFT_W-1:0] r_shift;
    logic        w_accept;
    logic        w_at_end;
    logic        w_store;
    logic        w_is_start;
    logic        w_is_zero;

    assign w_at_end   = (r_phase == sfd_pkg::PH_FRAME) && (r_count == sfd_pkg::END_BYTE);
    // Stall only the end byte, and only while no queue slot is free.
    assign i_rx.ready = !(w_at_end && i_q_full);
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_is_start = (i_rx.rx_byte == sfd_pkg::START_BYTE);
    assign w_is_zero  = (i_rx.rx_byte == sfd_pkg::ZERO_BYTE);
    assign w_store    = w_accept && (r_phase == sfd_pkg::PH_FRAME) &&
                        (r_count >= sfd_pkg::FIRST_DATA) &&
                        (r_count <= sfd_pkg::FLAG_BYTE);
    assign o_push     = w_accept && w_at_end;

    assign o_frame.data     = r_shift[sfd_pkg::DATA_W-1:0];
    assign o_frame.dig      = r_shift[sfd_pkg::DATA_W +: 2];
    assign o_frame.failsafe = r_shift[sfd_pkg::DATA_W + 3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfd_pkg::PH_EXPECT;
            r_count     <= '0;
            r_prev_zero <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_prev_zero <= n_prev_zero;
        end
    end

    // Oldest byte ends up in the low bits: byte 1 at [7:0], flags on top.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_shift <= {i_rx.rx_byte, r_shift[sfd_pkg::SHIFT_W-1:8]};
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_prev_zero = r_prev_zero;
        if (w_accept) begin
            case (r_phase)
                sfd_pkg::PH_HUNT: begin
                    if (w_is_start && r_prev_zero) begin
                        n_phase     = sfd_pkg::PH_FRAME;
                        n_count     = sfd_pkg::FIRST_DATA;
                        n_prev_zero = 1'b0;
                    end else begin
                        n_prev_zero = w_is_zero;
                    end
                end
                sfd_pkg::PH_FRAME: begin
                    if (r_count == sfd_pkg::END_BYTE) begin
                        n_phase     = sfd_pkg::PH_EXPECT;
                        n_count     = '0;
                        n_prev_zero = 1'b0;
                    end else begin
                        n_count = r_count + 5'd1;
                    end
                end
                default: begin
                    if (w_is_start) begin
                        n_phase     = sfd_pkg::PH_FRAME;
                        n_count     = sfd_pkg::FIRST_DATA;
                        n_prev_zero = 1'b0;
                    end else begin
                        n_phase     = sfd_pkg::PH_HUNT;
                        n_prev_zero = w_is_zero;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/sfd_queue.sv =====
// Two-entry frame queue between front and back.
`timescale 1ns / 1ps
module sfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfd_pkg::t_frame i_frame,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output sfd_pkg::t_frame o_frame
);

    sfd_pkg::t_frame r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_frame = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_frame;
        end
    end

endmodule

// ===== rtl/sfd_back.sv =====
// Back end: unpacks one frame into 18 channel results through an output register.
`timescale 1ns / 1ps
module sfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  sfd_pkg::t_frame i_frame,
    output logic            o_pop,
    sfd_chan_if.source      o_ch
);

    logic                       r_busy;
    logic [4:0]                 r_idx;
    logic [sfd_pkg::DATA_W-1:0] r_work;
    logic [1:0]                 r_dig;
    logic                       r_fs;
    logic                       r_ov;
    logic [4:0]                 r_ch;
    logic [10:0]                r_val;
    logic                       r_ofs;
    logic                       r_last;
    logic                       w_adv;
    logic [10:0]                w_val;
    logic                       w_dbit;

    assign o_pop = !r_busy && !i_q_empty;
    assign w_adv = r_busy && (!r_ov || o_ch.ready);

    assign w_dbit = r_idx[0] ? r_dig[1] : r_dig[0];
    assign w_val  = (r_idx < 5'(sfd_pkg::N_ANALOG)) ? r_work[sfd_pkg::CH_W-1:0] :
                    (w_dbit ? sfd_pkg::DIGITAL_ON : sfd_pkg::DIGITAL_OFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_adv) begin
                r_idx <= r_idx + 5'd1;
                if (r_idx == sfd_pkg::LAST_CH) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_ov <= 1'b1;
            end else if (o_ch.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Shift the packed channels down by one field per result.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_frame.data;
            r_dig  <= i_frame.dig;
            r_fs   <= i_frame.failsafe;
        end else if (w_adv) begin
            r_work <= r_work >> sfd_pkg::CH_W;
        end
        if (w_adv) begin
            r_ch   <= r_idx;
            r_val  <= w_val;
            r_ofs  <= r_fs;
            r_last <= (r_idx == sfd_pkg::LAST_CH);
        end
    end

    assign o_ch.valid         = r_ov;
    assign o_ch.channel_index = r_ch;
    assign o_ch.channel_value = r_val;
    assign o_ch.failsafe      = r_ofs;
    assign o_ch.last          = r_last;

endmodule

// ===== rtl/sbus_frame_decoder_unit.sv =====
// Top level of the SBUS frame decoder.
//
//  port    dir  payload                                        width
//  i_rx    in   rx_byte                                        8
//  o_ch    out  channel_index, channel_value, failsafe, last   5, 11, 1, 1
//
// One byte is taken per cycle while i_rx is not stalled; the front tracks sync and
// captures bytes 1..23. The end byte of a frame hands the frame to a two-entry
// queue; the back then pops it and emits 18 results, one per cycle while
// o_ch.ready is high. i_rx stalls only on an end byte while both queue slots
// are taken. Reset (i_rst_n low, synchronous) returns to waiting for a start byte.
`timescale 1ns / 1ps
module sbus_frame_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfd_byte_if.sink   i_rx,
    sfd_chan_if.source o_ch
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    sfd_pkg::t_frame w_in_frame;
    sfd_pkg::t_frame w_out_frame;

    sfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_q_full(w_full),
        .o_push  (w_push),
        .o_frame (w_in_frame)
    );

    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_in_frame),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_frame (w_out_frame)
    );

    sfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(w_empty),
        .i_frame  (w_out_frame),
        .o_pop    (w_pop),
        .o_ch     (o_ch)
    );

endmodule

// ===== test/tb_sbus_frame_decoder_unit.sv =====
// Self-checking testbench of the SBUS frame decoder unit.
`timescale 1ns / 1ps
module tb_sbus_frame_decoder_unit;

    localparam int FRAME_BYTES  = 25;
    localparam int N_CHANNELS   = 18;
    localparam int FAILSAFE_BIT = 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 11;

    typedef struct {
        logic [4:0]  idx;
        logic [10:0] value;
        logic        failsafe;
        logic        last;
    } t_chan_rec;

    class frame_scoreboard;
        sfd_pkg::t_phase phase;
        logic            prev_zero;
        logic [4:0]      count;
        logic [7:0]      store [sfd_pkg::STORE_BYTES];
        t_chan_rec       expected [$];
        int              errors;

        function new();
            phase     = sfd_pkg::PH_EXPECT;
            prev_zero = 1'b0;
            count     = 5'd0;
            errors    = 0;
            foreach (store[i]) store[i] = 8'h00;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function void start_frame();
            phase     = sfd_pkg::PH_FRAME;
            count     = sfd_pkg::FIRST_DATA;
            prev_zero = 1'b0;
        endfunction

        // Unpack the 16 analog channels and the two digital flags of a frame.
        function void decode_frame();
            logic [sfd_pkg::SHIFT_W-1:0] bits;
            logic [7:0]                  flags;
            t_chan_rec                   r;
            for (int i = 0; i < sfd_pkg::STORE_BYTES; i++) bits[i*8 +: 8] = store[i];
            flags = store[sfd_pkg::FLAG_BYTE - sfd_pkg::FIRST_DATA];
            for (int ch = 0; ch < N_CHANNELS; ch++) begin
                r.idx = 5'(ch);
                if (ch < sfd_pkg::N_ANALOG) begin
                    r.value = bits[ch*sfd_pkg::CH_W +: sfd_pkg::CH_W];
                end else begin
                    r.value = flags[ch - sfd_pkg::N_ANALOG] ? sfd_pkg::DIGITAL_ON :
                                                              sfd_pkg::DIGITAL_OFF;
                end
                r.failsafe = flags[FAILSAFE_BIT];
                r.last     = (5'(ch) == sfd_pkg::LAST_CH);
                expected.push_back(r);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                sfd_pkg::PH_HUNT: begin
                    if (b == sfd_pkg::START_BYTE && prev_zero) start_frame();
                    else prev_zero = (b == sfd_pkg::ZERO_BYTE);
                end
                sfd_pkg::PH_FRAME: begin
                    if (count >= sfd_pkg::FIRST_DATA && count <= sfd_pkg::FLAG_BYTE)
                        store[count - sfd_pkg::FIRST_DATA] = b;
                    if (int'(count) + 1 < FRAME_BYTES) begin
                        count++;
                    end else begin
                        phase     = sfd_pkg::PH_EXPECT;
                        count     = 5'd0;
                        prev_zero = 1'b0;
                        decode_frame();
                    end
                end
                default: begin
                    if (b == sfd_pkg::START_BYTE) begin
                        start_frame();
                    end else begin
                        phase     = sfd_pkg::PH_HUNT;
                        prev_zero = (b == sfd_pkg::ZERO_BYTE);
                    end
                end
            endcase
        endfunction

        task check_result(t_chan_rec got);
            t_chan_rec want;
            if (expected.size() == 0) begin
                report($sformatf("unexpected result: channel %0d value %0d",
                                 got.idx, got.value));
            end else begin
                want = expected.pop_front();
                if (got.idx !== want.idx)
                    report($sformatf("channel_index got %0d want %0d", got.idx, want.idx));
                if (got.value !== want.value)
                    report($sformatf("channel %0d value got %0d want %0d",
                                     want.idx, got.value, want.value));
                if (got.failsafe !== want.failsafe)
                    report($sformatf("channel %0d failsafe got %b want %b",
                                     want.idx, got.failsafe, want.failsafe));
                if (got.last !== want.last)
                    report($sformatf("channel %0d last got %b want %b",
                                     want.idx, got.last, want.last));
            end
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   cycles = 0;

    frame_scoreboard sb = new();

    sfd_byte_if rx_if ();
    sfd_chan_if ch_if ();

    sbus_frame_decoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_ch    (ch_if)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sbus_frame_decoder_unit: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        int hold_left;
        hold_left   = 0;
        ch_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                ch_if.ready = 1'b0;
                hold_left--;
            end else if (hold_done != hold_reqs) begin
                hold_done++;
                hold_left   = HOLD_CYCLES - 1;
                ch_if.ready = 1'b0;
            end else begin
                ch_if.ready = steady || ($urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge clk) begin
        t_chan_rec got;
        if (rst_n && ch_if.valid && ch_if.ready) begin
            got.idx      = ch_if.channel_index;
            got.value    = ch_if.channel_value;
            got.failsafe = ch_if.failsafe;
            got.last     = ch_if.last;
            sb.check_result(got);
        end
    end

    // Offer one byte from a falling edge; return at the falling edge after acceptance.
    task automatic send_byte(logic [7:0] b);
        while (!steady && $urandom_range(99) < 17) begin
            rx_if.valid = 1'b0;
            @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    // Send one whole frame; fill < 0 gives random data bytes.
    task automatic send_frame(logic [7:0] flags, int fill, bit via_hunt);
        // finish any frame already in flight
        while (sb.phase == sfd_pkg::PH_FRAME) send_byte(8'($urandom));
        if (sb.phase == sfd_pkg::PH_HUNT || via_hunt) send_byte(sfd_pkg::ZERO_BYTE);
        send_byte(sfd_pkg::START_BYTE);
        for (int i = sfd_pkg::FIRST_DATA; i < sfd_pkg::FLAG_BYTE; i++)
            send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
        send_byte(flags);
        send_byte(8'($urandom));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(2))
                0:       send_byte(sfd_pkg::ZERO_BYTE);
                1:       send_byte(sfd_pkg::START_BYTE);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    function automatic int pick_fill();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 255;
            default: return -1;
        endcase
    endfunction

    task automatic wait_drained();
        while (sb.expected.size() != 0) @(negedge clk);
    endtask

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // hunt entry, a start byte that must not sync, then sync through 0x00 0x0F
        send_byte(8'h55);
        send_byte(sfd_pkg::START_BYTE);
        send_frame(8'h0F, 255, 1'b0);

        // hold the result side while frames keep coming, so the input stalls
        hold_reqs++;
        // start byte taken at once after a frame; all-zero data, flags clear
        send_frame(8'h00, 0, 1'b0);
        repeat (2) send_frame(8'($urandom), pick_fill(), $urandom_range(3) == 0);
        rx_if.valid = 1'b0;
        wait_drained();

        steady = 1'b1;
        send_noise();
        send_frame(8'($urandom), -1, 1'b1);
        rx_if.valid = 1'b0;
        wait_drained();
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0) begin
            $display("sbus_frame_decoder_unit: match");
        end else begin
            $display("sbus_frame_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
